// File: sv/smc_pkg.sv
// Shared constants, codes and types of the sprite mask collision core.
package smc_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;

    localparam int ROWS    = 32;
    localparam int ROW_W   = 32;
    localparam int ADDR_W  = $clog2(ROWS);
    localparam int SIZE_W  = 6;
    localparam int POS_W   = 16;
    localparam int COORD_W = POS_W + 2;
    localparam int DIFF_W  = SIZE_W + 1;
    localparam int EXT_W   = 2 ** SIZE_W;
    localparam int CIDX_W  = 4;

    localparam logic [SIZE_W:0] ROWS_LIM = (SIZE_W + 1)'(ROWS);
    localparam logic [SIZE_W:0] WIDTH_LIM = (SIZE_W + 1)'(MAX_WIDTH);
    localparam logic [SIZE_W:0] HEIGHT_LIM = (SIZE_W + 1)'(MAX_HEIGHT);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam logic MASK_A    = 1'b0;
    localparam logic MASK_B    = 1'b1;

    localparam logic [CIDX_W-1:0] REG_WIDTH_A  = 4'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT_A = 4'd1;
    localparam logic [CIDX_W-1:0] REG_WIDTH_B  = 4'd2;
    localparam logic [CIDX_W-1:0] REG_HEIGHT_B = 4'd3;
    localparam logic [CIDX_W-1:0] REG_OFFSET_AX = 4'd4;
    localparam logic [CIDX_W-1:0] REG_OFFSET_AY = 4'd5;
    localparam logic [CIDX_W-1:0] REG_OFFSET_BX = 4'd6;
    localparam logic [CIDX_W-1:0] REG_OFFSET_BY = 4'd7;

    typedef struct packed {
        logic [SIZE_W-1:0]       width_a;
        logic [SIZE_W-1:0]       height_a;
        logic [SIZE_W-1:0]       width_b;
        logic [SIZE_W-1:0]       height_b;
        logic signed [POS_W-1:0] offset_ax;
        logic signed [POS_W-1:0] offset_ay;
        logic signed [POS_W-1:0] offset_bx;
        logic signed [POS_W-1:0] offset_by;
    } cfg_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        wa;
        logic [SIZE_W-1:0]        wb;
        logic                     fha;
        logic                     fhb;
        logic signed [DIFF_W-1:0] d;
        logic                     row_ok_a;
        logic                     row_ok_b;
    } geom_t;

endpackage

// File: sv/smc_mask_ram.sv
// Mask row store: one write port, one registered read port.
module smc_mask_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/smc_row_match.sv
// Row pair test: crops both rows (mirroring a flipped one), aligns B onto A and checks for a common pixel.
module smc_row_match
    import smc_pkg::*;
(
    input  logic [ROW_W-1:0] row_a,
    input  logic [ROW_W-1:0] row_b,
    input  geom_t            geom,
    output logic             row_hit
);

    function automatic logic [EXT_W-1:0] crop_row(input logic [ROW_W-1:0] row,
                                                  input logic ok,
                                                  input logic [SIZE_W-1:0] w,
                                                  input logic flip);
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] rev;
        logic [SIZE_W:0]  sh;
        ext = ok ? {{(EXT_W - ROW_W){1'b0}}, row} : '0;
        for (int i = 0; i < EXT_W; i++)
        begin
            rev[i] = ext[EXT_W-1-i];
        end
        sh = (SIZE_W + 1)'(EXT_W) - {1'b0, w};
        if (flip)
        begin
            return rev >> sh;
        end
        return ext & ~({EXT_W{1'b1}} << w);
    endfunction

    logic [EXT_W-1:0]  ma;
    logic [EXT_W-1:0]  mb;
    logic [EXT_W-1:0]  mb_aligned;
    logic [DIFF_W-1:0] d_mag;

    always_comb
    begin
        ma    = crop_row(row_a, geom.row_ok_a, geom.wa, geom.fha);
        mb    = crop_row(row_b, geom.row_ok_b, geom.wb, geom.fhb);
        d_mag = geom.d[DIFF_W-1] ? DIFF_W'(-geom.d) : DIFF_W'(geom.d);
        if (geom.d[DIFF_W-1])
        begin
            mb_aligned = mb >> d_mag;
        end
        else
        begin
            mb_aligned = mb << d_mag;
        end
        row_hit = |(ma & mb_aligned);
    end

endmodule

// File: sv/smc_query_ctrl.sv
// Query sequencer: box test, overlap span set-up and the row-pair scan over the mask stores.
module smc_query_ctrl
    import smc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    action,
    input  logic signed [POS_W-1:0] pos_ax,
    input  logic signed [POS_W-1:0] pos_ay,
    input  logic                    flip_h_a,
    input  logic                    flip_v_a,
    input  logic signed [POS_W-1:0] pos_bx,
    input  logic signed [POS_W-1:0] pos_by,
    input  logic                    flip_h_b,
    input  logic                    flip_v_b,
    input  cfg_t                    cfg,
    input  logic                    row_hit,
    output logic                    busy,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr_a,
    output logic [ADDR_W-1:0]       rd_addr_b,
    output geom_t                   geom,
    output logic                    done,
    output logic                    collides,
    output logic                    boxes_overlap
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BOX   = 3'd1;
    localparam logic [2:0] S_SPAN  = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [SIZE_W-1:0] wa_reg, ha_reg, wb_reg, hb_reg;
    logic              fha_reg, fva_reg, fhb_reg, fvb_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [COORD_W-1:0] ea_reg, eb_reg, fa_reg, fb_reg;
    logic signed [DIFF_W-1:0]  d_reg;
    logic [SIZE_W-1:0] ya0_reg, yb0_reg, n_reg;
    logic [SIZE_W-1:0] ptr_a_reg, ptr_b_reg, cnt_reg;
    logic              dv_reg, ok_a_reg, ok_b_reg, hit_reg;
    logic              done_reg, done_next;
    logic              col_reg, col_next;
    logic              box_reg, box_next;

    logic              accept_q;
    logic              overlap;
    logic signed [COORD_W-1:0] y0, y1, span;

    function automatic logic [SIZE_W-1:0] clamp(input logic [SIZE_W-1:0] v,
                                                input logic [SIZE_W:0] lim);
        return ({1'b0, v} > lim) ? SIZE_W'(lim) : v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sx(input logic signed [POS_W-1:0] v);
        return {{(COORD_W - POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic logic signed [COORD_W-1:0] zx(input logic [SIZE_W-1:0] v);
        return $signed({{(COORD_W - SIZE_W){1'b0}}, v});
    endfunction

    assign accept_q = start && !busy && (action == ACT_QUERY);
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        overlap = (wa_reg != '0) && (ha_reg != '0) && (wb_reg != '0) && (hb_reg != '0)
                  && (ax_reg < eb_reg) && (bx_reg < ea_reg)
                  && (ay_reg < fb_reg) && (by_reg < fa_reg);
        y0   = (ay_reg > by_reg) ? ay_reg : by_reg;
        y1   = (fa_reg < fb_reg) ? fa_reg : fb_reg;
        span = y1 - y0;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        col_next   = col_reg;
        box_next   = box_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_q)
                begin
                    state_next = S_BOX;
                end
            end
            S_BOX:
            begin
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                if (overlap)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    col_next   = 1'b0;
                    box_next   = 1'b0;
                end
            end
            S_INIT:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg == n_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                col_next   = hit_reg | (dv_reg & row_hit);
                box_next   = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            dv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            dv_reg    <= (state_reg == S_SCAN);
            if (state_reg == S_INIT)
            begin
                hit_reg <= 1'b0;
                cnt_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (dv_reg && row_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        box_reg <= box_next;
        if (accept_q)
        begin
            wa_reg  <= clamp(cfg.width_a, WIDTH_LIM);
            ha_reg  <= clamp(cfg.height_a, HEIGHT_LIM);
            wb_reg  <= clamp(cfg.width_b, WIDTH_LIM);
            hb_reg  <= clamp(cfg.height_b, HEIGHT_LIM);
            fha_reg <= flip_h_a;
            fva_reg <= flip_v_a;
            fhb_reg <= flip_h_b;
            fvb_reg <= flip_v_b;
            ax_reg  <= sx(pos_ax) + sx(cfg.offset_ax);
            ay_reg  <= sx(pos_ay) + sx(cfg.offset_ay);
            bx_reg  <= sx(pos_bx) + sx(cfg.offset_bx);
            by_reg  <= sx(pos_by) + sx(cfg.offset_by);
        end
        if (state_reg == S_BOX)
        begin
            ea_reg <= ax_reg + zx(wa_reg);
            eb_reg <= bx_reg + zx(wb_reg);
            fa_reg <= ay_reg + zx(ha_reg);
            fb_reg <= by_reg + zx(hb_reg);
        end
        if (state_reg == S_SPAN)
        begin
            d_reg   <= DIFF_W'(bx_reg - ax_reg);
            ya0_reg <= SIZE_W'(y0 - ay_reg);
            yb0_reg <= SIZE_W'(y0 - by_reg);
            n_reg   <= SIZE_W'(span);
        end
        if (state_reg == S_INIT)
        begin
            ptr_a_reg <= fva_reg ? (ha_reg - 1'b1 - ya0_reg) : ya0_reg;
            ptr_b_reg <= fvb_reg ? (hb_reg - 1'b1 - yb0_reg) : yb0_reg;
        end
        if (state_reg == S_SCAN)
        begin
            ok_a_reg  <= ({1'b0, ptr_a_reg} < ROWS_LIM);
            ok_b_reg  <= ({1'b0, ptr_b_reg} < ROWS_LIM);
            ptr_a_reg <= fva_reg ? (ptr_a_reg - 1'b1) : (ptr_a_reg + 1'b1);
            ptr_b_reg <= fvb_reg ? (ptr_b_reg - 1'b1) : (ptr_b_reg + 1'b1);
        end
    end

    assign rd_en     = (state_reg == S_SCAN);
    assign rd_addr_a = ptr_a_reg[ADDR_W-1:0];
    assign rd_addr_b = ptr_b_reg[ADDR_W-1:0];

    always_comb
    begin
        geom.wa       = wa_reg;
        geom.wb       = wb_reg;
        geom.fha      = fha_reg;
        geom.fhb      = fhb_reg;
        geom.d        = d_reg;
        geom.row_ok_a = ok_a_reg;
        geom.row_ok_b = ok_b_reg;
    end

    assign done          = done_reg;
    assign collides      = col_reg;
    assign boxes_overlap = box_reg;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_DRAIN || $past(state_reg) == S_SPAN))
        else $error("result strobe without a finished query");

    a_hit_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && col_reg) |-> box_reg)
        else $error("collision reported with boxes apart");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (cnt_reg < n_reg))
        else $error("row read beyond the overlap span");

    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> ($past(state_reg) == S_SCAN && dv_reg))
        else $error("drain without a pending row pair");

endmodule

// File: sv/sprite_mask_collision_core.sv
// Top level of the sprite mask collision core: configuration registers, mask stores and scan.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the register
//   (0..7: width_a, height_a, width_b, height_b, offset_ax, offset_ay, offset_bx,
//   offset_by), cfg_data carries the value. Other indexes are ignored. Write only idle.
//   Commands: a transaction is taken on a clock edge with start high and busy low.
//   action selects a mask row load (mask_select, row_index, row_bits) or a query.
//   A row load is written to the selected mask store, busy stays low and no result follows.
//   A query raises busy; collides and boxes_overlap appear with done for one cycle.
//   A query ends after the box test when either sprite has zero width or height or the boxes
//   are apart, otherwise after a scan of the N overlapping rows (1..32):
//   one row pair is read from the two mask stores and tested per cycle.
//   A new command may be given in the cycle that done is high.
//   The receiver cannot stall: each result is offered once and is not held.
//   Reset clears all configuration registers to zero and returns the sequencer to idle;
//   mask rows read as undefined until loaded.
module sprite_mask_collision_core
    import smc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    action,
    input  logic                    mask_select,
    input  logic [ADDR_W-1:0]       row_index,
    input  logic [ROW_W-1:0]        row_bits,
    input  logic signed [POS_W-1:0] pos_ax,
    input  logic signed [POS_W-1:0] pos_ay,
    input  logic                    flip_h_a,
    input  logic                    flip_v_a,
    input  logic signed [POS_W-1:0] pos_bx,
    input  logic signed [POS_W-1:0] pos_by,
    input  logic                    flip_h_b,
    input  logic                    flip_v_b,
    output logic                    done,
    output logic                    collides,
    output logic                    boxes_overlap,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CIDX_W-1:0]       cfg_index,
    input  logic [POS_W-1:0]        cfg_data
);

    cfg_t              cfg_reg;
    logic              cfg_we;
    logic              load_we;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [ROW_W-1:0]  row_a, row_b;
    geom_t             geom;
    logic              row_hit;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH_A:   cfg_reg.width_a   <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT_A:  cfg_reg.height_a  <= cfg_data[SIZE_W-1:0];
                REG_WIDTH_B:   cfg_reg.width_b   <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT_B:  cfg_reg.height_b  <= cfg_data[SIZE_W-1:0];
                REG_OFFSET_AX: cfg_reg.offset_ax <= $signed(cfg_data);
                REG_OFFSET_AY: cfg_reg.offset_ay <= $signed(cfg_data);
                REG_OFFSET_BX: cfg_reg.offset_bx <= $signed(cfg_data);
                REG_OFFSET_BY: cfg_reg.offset_by <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign load_we = start && !busy && (action == ACT_LOAD);

    smc_mask_ram #(
        .DEPTH (ROWS),
        .WIDTH (ROW_W)
    ) u_ram_a (
        .clk   (clk),
        .we    (load_we && (mask_select == MASK_A)),
        .waddr (row_index),
        .wdata (row_bits),
        .re    (rd_en),
        .raddr (rd_addr_a),
        .rdata (row_a)
    );

    smc_mask_ram #(
        .DEPTH (ROWS),
        .WIDTH (ROW_W)
    ) u_ram_b (
        .clk   (clk),
        .we    (load_we && (mask_select == MASK_B)),
        .waddr (row_index),
        .wdata (row_bits),
        .re    (rd_en),
        .raddr (rd_addr_b),
        .rdata (row_b)
    );

    smc_row_match u_match (
        .row_a   (row_a),
        .row_b   (row_b),
        .geom    (geom),
        .row_hit (row_hit)
    );

    smc_query_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .pos_ax        (pos_ax),
        .pos_ay        (pos_ay),
        .flip_h_a      (flip_h_a),
        .flip_v_a      (flip_v_a),
        .pos_bx        (pos_bx),
        .pos_by        (pos_by),
        .flip_h_b      (flip_h_b),
        .flip_v_b      (flip_v_b),
        .cfg           (cfg_reg),
        .row_hit       (row_hit),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .geom          (geom),
        .done          (done),
        .collides      (collides),
        .boxes_overlap (boxes_overlap)
    );

endmodule
